// ----- rtl/lbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lbpm_pkg
// Types and constants shared by the buffer pool manager modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbpm_pkg;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_MARK  = 2'd1;
   localparam logic [1:0] MODE_SYNC  = 2'd2;
   localparam logic [1:0] MODE_RESET = 2'd3;

   localparam logic [15:0] PIN_MAX   = 16'hFFFF;
   localparam int          SYNC_MAX  = 64;
   localparam int          CNT_W     = 7;

   typedef struct packed {
      logic [31:0] rel;
      logic [15:0] pin;
      logic        dirty;
   } slot_entry_type;

   typedef struct packed {
      logic           en_slot;
      logic           en_tag;
      slot_entry_type slot;
      logic [31:0]    tag;
   } mem_write_type;

   typedef struct packed {
      logic [31:0] rel;
      logic [31:0] blk;
      logic        dirty;
   } victim_type;

   typedef struct packed {
      logic        found;
      logic [5:0]  slot_index;
      logic        no_free_error;
      logic [31:0] assigned_block;
      logic        writeback_valid;
      logic [31:0] writeback_rel;
      logic [31:0] writeback_block;
      logic        last;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_ALLOC_PICK,
      ST_MARK_READ,
      ST_MARK_WRITE,
      ST_SYNC_READ,
      ST_SYNC_DATA,
      ST_SYNC_END,
      ST_RESULT
   } state_type;

endpackage

// ----- rtl/lbpm_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lbpm_slot_ram
// Slot state storage: relation tag, pin count and dirty bit in one array,
// block tag in another. One write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbpm_slot_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                   clock,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  lbpm_pkg::mem_write_type wr,
   output lbpm_pkg::slot_entry_type rd_slot,
   output logic [31:0]            rd_tag
);
   import lbpm_pkg::*;

   slot_entry_type slot_mem [DEPTH];
   logic [31:0]    tag_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en_slot) begin
         slot_mem[wr_addr] <= wr.slot;
      end
      rd_slot <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.en_tag) begin
         tag_mem[wr_addr] <= wr.tag;
      end
      rd_tag <= tag_mem[rd_addr];
   end

endmodule

// ----- rtl/local_buffer_pool_manager.sv -----
// ----------------------------------------------------------------------------
// local_buffer_pool_manager
// Buffer slot pool with tag lookup, round-robin victim choice, dirty tracking
// and flush.
// ----------------------------------------------------------------------------
// Use: a request on req_* (valid/stall) carries a mode. Alloc returns one
// response on rsp_* with slot, hit flag or no-free error and any victim
// write-back. Mark dirty and pool reset return nothing. Sync returns one
// response per dirty slot in slot order (up to 64), last on the final one.
// Flow: an alloc makes one pipelined pass over the slot memory, checking tags
// and collecting victim candidates at once; a hit ends the pass early, a miss
// goes on to a pick state, and either then waits in a result state for the
// output register. Mark dirty reads the slot and then writes it back. Sync
// reads and writes each slot in turn, then ends, waiting on response stalls;
// reset pool runs the clearing pass below.
// After reset, and after a pool reset request, a clearing pass writes every
// slot, one per cycle; no request is taken meanwhile.
// Responses sit in an output register; a stalled response holds its value,
// and a sync pass waits at a dirty slot while pending and output are both full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_buffer_pool_manager #(
   parameter int SLOT_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_rel_id,
   input  logic [31:0] req_block_num,
   input  logic        req_new_block,
   input  logic [31:0] req_relation_size,
   input  logic [5:0]  req_slot_select,
   input  logic        req_release_pin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_no_free_error,
   output logic [31:0] rsp_assigned_block,
   output logic        rsp_writeback_valid,
   output logic [31:0] rsp_writeback_rel,
   output logic [31:0] rsp_writeback_block,
   output logic        rsp_last
);
   import lbpm_pkg::*;

   localparam int          IW   = $clog2(SLOT_COUNT);
   localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

   state_type      state_ff, state_in;
   logic [IW-1:0]  addr_ff, addr_in;
   logic [IW-1:0]  didx_ff;
   logic           dvld_ff, dvld_in;
   logic           iss_done_ff, iss_done_in;
   logic [31:0]    rel_ff, rel_in, blk_ff, blk_in;
   logic           rp_ff, rp_in;
   logic           clr_all_ff, clr_all_in;
   logic [IW-1:0]  nv_ff, nv_in;
   logic           c0_v_ff, c0_v_in, c1_v_ff, c1_v_in;
   logic [IW-1:0]  c0_idx_ff, c0_idx_in, c1_idx_ff, c1_idx_in;
   victim_type     c0_ff, c0_in, c1_ff, c1_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           pend_v_ff, pend_v_in;
   result_type     pend_ff, pend_in;
   result_type     out_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           push;
   result_type     push_data;
   mem_write_type  wr;
   logic [IW-1:0]  wr_addr;
   slot_entry_type rd_slot;
   logic [31:0]    rd_tag;

   logic           accept, out_free, hit, scan_end, report, sync_hold, sel_ok;
   logic [31:0]    sel_ext, didx_ext, vidx_ext;
   logic [IW-1:0]  vidx;
   victim_type     vic;

   lbpm_slot_ram #(.DEPTH(SLOT_COUNT), .AW(IW)) u_ram (
      .clock   (clock),
      .rd_addr (addr_ff),
      .wr_addr (wr_addr),
      .wr      (wr),
      .rd_slot (rd_slot),
      .rd_tag  (rd_tag)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sel_ext   = 32'(req_slot_select);
   assign sel_ok    = sel_ext < 32'(SLOT_COUNT);
   assign didx_ext  = 32'(didx_ff);
   assign hit       = dvld_ff && (rd_slot.rel != 32'd0) && (rd_slot.rel == rel_ff)
                      && (rd_tag == blk_ff);
   assign scan_end  = dvld_ff && (didx_ff == LAST);
   assign report    = rd_slot.dirty && (cnt_ff < CNT_W'(SYNC_MAX));
   assign sync_hold = report && pend_v_ff && !out_free;
   assign vidx      = c0_v_ff ? c0_idx_ff : c1_idx_ff;
   assign vic       = c0_v_ff ? c0_ff : c1_ff;
   assign vidx_ext  = 32'(vidx);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (addr_ff == LAST) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_ALLOC: state_in = ST_ALLOC_SCAN;
                  MODE_MARK:  state_in = sel_ok ? ST_MARK_READ : ST_IDLE;
                  MODE_SYNC:  state_in = ST_SYNC_READ;
                  MODE_RESET: state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ALLOC_SCAN: begin
            if (hit) state_in = ST_RESULT;
            else if (scan_end) state_in = ST_ALLOC_PICK;
         end
         ST_ALLOC_PICK: state_in = ST_RESULT;
         ST_MARK_READ:  state_in = ST_MARK_WRITE;
         ST_MARK_WRITE: state_in = ST_IDLE;
         ST_SYNC_READ:  state_in = ST_SYNC_DATA;
         ST_SYNC_DATA: begin
            if (!sync_hold) state_in = (addr_ff == LAST) ? ST_SYNC_END : ST_SYNC_READ;
         end
         ST_SYNC_END:   if (!pend_v_ff || out_free) state_in = ST_IDLE;
         ST_RESULT:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and memory writes
   always_comb begin
      addr_in     = addr_ff;
      dvld_in     = dvld_ff;
      iss_done_in = iss_done_ff;
      rel_in      = rel_ff;
      blk_in      = blk_ff;
      rp_in       = rp_ff;
      clr_all_in  = clr_all_ff;
      nv_in       = nv_ff;
      c0_v_in     = c0_v_ff;
      c1_v_in     = c1_v_ff;
      c0_idx_in   = c0_idx_ff;
      c1_idx_in   = c1_idx_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      cnt_in      = cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      push        = 1'b0;
      push_data   = pend_ff;
      wr          = '0;
      wr_addr     = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr.en_slot = 1'b1;
            wr.en_tag  = clr_all_ff;
            addr_in    = addr_ff + IW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               rel_in      = req_rel_id;
               blk_in      = req_new_block ? req_relation_size : req_block_num;
               rp_in       = req_release_pin;
               addr_in     = (req_mode == MODE_MARK) ? sel_ext[IW-1:0] : '0;
               dvld_in     = 1'b0;
               iss_done_in = 1'b0;
               c0_v_in     = 1'b0;
               c1_v_in     = 1'b0;
               cnt_in      = '0;
               pend_v_in   = 1'b0;
               clr_all_in  = 1'b0;
               if (req_mode == MODE_SYNC || req_mode == MODE_RESET) nv_in = '0;
            end
         end
         ST_ALLOC_SCAN: begin
            dvld_in = !iss_done_ff;
            if (!iss_done_ff) begin
               if (addr_ff == LAST) iss_done_in = 1'b1;
               else addr_in = addr_ff + IW'(1);
            end
            // first unpinned at or after the pointer, and first unpinned overall
            if (dvld_ff && rd_slot.pin == 16'd0) begin
               if (!c0_v_ff && didx_ff >= nv_ff) begin
                  c0_v_in   = 1'b1;
                  c0_idx_in = didx_ff;
                  c0_in     = '{rel: rd_slot.rel, blk: rd_tag, dirty: rd_slot.dirty};
               end
               if (!c1_v_ff) begin
                  c1_v_in   = 1'b1;
                  c1_idx_in = didx_ff;
                  c1_in     = '{rel: rd_slot.rel, blk: rd_tag, dirty: rd_slot.dirty};
               end
            end
            if (hit) begin
               wr.en_slot = 1'b1;
               wr_addr    = didx_ff;
               wr.slot    = rd_slot;
               if (rd_slot.pin != PIN_MAX) wr.slot.pin = rd_slot.pin + 16'd1;
               pend_in = '{found: 1'b1, slot_index: didx_ext[5:0], no_free_error: 1'b0,
                           assigned_block: blk_ff, writeback_valid: 1'b0,
                           writeback_rel: 32'd0, writeback_block: 32'd0, last: 1'b1};
            end
         end
         ST_ALLOC_PICK: begin
            if (c0_v_ff || c1_v_ff) begin
               wr.en_slot = 1'b1;
               wr.en_tag  = 1'b1;
               wr_addr    = vidx;
               wr.slot    = '{rel: rel_ff, pin: 16'd1, dirty: 1'b0};
               wr.tag     = blk_ff;
               nv_in      = (vidx == LAST) ? '0 : vidx + IW'(1);
               pend_in = '{found: 1'b0, slot_index: vidx_ext[5:0], no_free_error: 1'b0,
                           assigned_block: blk_ff, writeback_valid: vic.dirty,
                           writeback_rel: vic.dirty ? vic.rel : 32'd0,
                           writeback_block: vic.dirty ? vic.blk : 32'd0, last: 1'b1};
            end else begin
               pend_in = '{found: 1'b0, slot_index: 6'd0, no_free_error: 1'b1,
                           assigned_block: blk_ff, writeback_valid: 1'b0,
                           writeback_rel: 32'd0, writeback_block: 32'd0, last: 1'b1};
            end
         end
         ST_MARK_WRITE: begin
            wr.en_slot = 1'b1;
            wr.slot    = '{rel: rd_slot.rel, pin: rd_slot.pin, dirty: 1'b1};
            if (rp_ff && rd_slot.pin != 16'd0) wr.slot.pin = rd_slot.pin - 16'd1;
         end
         ST_SYNC_DATA: begin
            if (!sync_hold) begin
               wr.en_slot = 1'b1;
               wr.slot    = '{rel: rd_slot.rel, pin: 16'd0, dirty: rd_slot.dirty && !report};
               if (addr_ff != LAST) addr_in = addr_ff + IW'(1);
               if (report) begin
                  // earlier flush entry is not the last one
                  if (pend_v_ff) push = 1'b1;
                  pend_v_in = 1'b1;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  pend_in = '{found: 1'b0, slot_index: didx_ext[5:0], no_free_error: 1'b0,
                              assigned_block: 32'd0, writeback_valid: 1'b1,
                              writeback_rel: rd_slot.rel, writeback_block: rd_tag,
                              last: 1'b0};
               end
            end
         end
         ST_SYNC_END: begin
            if (pend_v_ff && out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               pend_v_in      = 1'b0;
            end
         end
         ST_RESULT: begin
            if (out_free) push = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         clr_all_ff   <= 1'b1;
         nv_ff        <= '0;
         dvld_ff      <= 1'b0;
         iss_done_ff  <= 1'b0;
         c0_v_ff      <= 1'b0;
         c1_v_ff      <= 1'b0;
         cnt_ff       <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         clr_all_ff   <= clr_all_in;
         nv_ff        <= nv_in;
         dvld_ff      <= dvld_in;
         iss_done_ff  <= iss_done_in;
         c0_v_ff      <= c0_v_in;
         c1_v_ff      <= c1_v_in;
         cnt_ff       <= cnt_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff   <= addr_ff;
      rel_ff    <= rel_in;
      blk_ff    <= blk_in;
      rp_ff     <= rp_in;
      c0_idx_ff <= c0_idx_in;
      c1_idx_ff <= c1_idx_in;
      c0_ff     <= c0_in;
      c1_ff     <= c1_in;
      pend_ff   <= pend_in;
      if (push) out_ff <= push_data;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = out_ff.found;
   assign rsp_slot_index      = out_ff.slot_index;
   assign rsp_no_free_error   = out_ff.no_free_error;
   assign rsp_assigned_block  = out_ff.assigned_block;
   assign rsp_writeback_valid = out_ff.writeback_valid;
   assign rsp_writeback_rel   = out_ff.writeback_rel;
   assign rsp_writeback_block = out_ff.writeback_block;
   assign rsp_last            = out_ff.last;

endmodule

// ----- rtl/lbpm_checker.sv -----
// ----------------------------------------------------------------------------
// lbpm_checker
// Port-level checks on the buffer pool manager responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [5:0]  rsp_slot_index,
   input logic        rsp_no_free_error,
   input logic        rsp_writeback_valid,
   input logic [31:0] rsp_writeback_rel,
   input logic [31:0] rsp_writeback_block,
   input logic        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writeback_valid |->
         rsp_writeback_rel == 32'd0 && rsp_writeback_block == 32'd0)
      else $error("write-back fields set without write-back");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_free_error |->
         !rsp_found && !rsp_writeback_valid && rsp_last && rsp_slot_index == 6'd0)
      else $error("bad no-free response");

   a_hit_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_last && !rsp_writeback_valid && !rsp_no_free_error)
      else $error("bad hit response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind local_buffer_pool_manager lbpm_checker u_lbpm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_found           (rsp_found),
   .rsp_slot_index      (rsp_slot_index),
   .rsp_no_free_error   (rsp_no_free_error),
   .rsp_writeback_valid (rsp_writeback_valid),
   .rsp_writeback_rel   (rsp_writeback_rel),
   .rsp_writeback_block (rsp_writeback_block),
   .rsp_last            (rsp_last)
);

// ----- test/lbpm_checker.sv -----
// ----------------------------------------------------------------------------
// lbpm_scoreboard
// Watches the request and response channels of the buffer pool manager,
// keeps a shadow copy of the slot pool, and checks each response against
// the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbpm_scoreboard
   import lbpm_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_rel_id,
   input  logic [31:0] req_block_num,
   input  logic        req_new_block,
   input  logic [31:0] req_relation_size,
   input  logic [5:0]  req_slot_select,
   input  logic        req_release_pin,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_found,
   input  logic [5:0]  rsp_slot_index,
   input  logic        rsp_no_free_error,
   input  logic [31:0] rsp_assigned_block,
   input  logic        rsp_writeback_valid,
   input  logic [31:0] rsp_writeback_rel,
   input  logic [31:0] rsp_writeback_block,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_count,
   output int          hit_count,
   output int          wb_count,
   output int          full_count
);

   logic [31:0] shadow_rel [SLOTS];
   logic [31:0] shadow_blk [SLOTS];
   logic [15:0] shadow_pin [SLOTS];
   logic        shadow_dirty [SLOTS];
   int          victim_ptr;
   result_type  expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic result_type mk(logic f, logic [5:0] s, logic e, logic [31:0] b,
                                     logic wv, logic [31:0] wr, logic [31:0] wb,
                                     logic l);
      result_type r;
      r.found = f; r.slot_index = s; r.no_free_error = e; r.assigned_block = b;
      r.writeback_valid = wv; r.writeback_rel = wr; r.writeback_block = wb;
      r.last = l;
      return r;
   endfunction

   task automatic pool_alloc(logic [31:0] rel, logic [31:0] blk);
      int s;
      bit got;
      got = 0;
      s = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_rel[i] != 0 && shadow_rel[i] == rel && shadow_blk[i] == blk) begin
            if (shadow_pin[i] != PIN_MAX) shadow_pin[i]++;
            expected_rsp.push_back(mk(1'b1, i[5:0], 1'b0, blk, 1'b0, 32'd0, 32'd0, 1'b1));
            return;
         end
      end
      for (int i = 0; i < SLOTS && !got; i++) begin
         if (shadow_pin[(victim_ptr + i) % SLOTS] == 0) begin
            s = (victim_ptr + i) % SLOTS;
            got = 1;
         end
      end
      if (!got) begin
         expected_rsp.push_back(mk(1'b0, 6'd0, 1'b1, blk, 1'b0, 32'd0, 32'd0, 1'b1));
         return;
      end
      if (shadow_pin[s] != PIN_MAX) shadow_pin[s]++;
      victim_ptr = (s + 1) % SLOTS;
      if (shadow_dirty[s])
         expected_rsp.push_back(mk(1'b0, s[5:0], 1'b0, blk, 1'b1, shadow_rel[s],
                                   shadow_blk[s], 1'b1));
      else
         expected_rsp.push_back(mk(1'b0, s[5:0], 1'b0, blk, 1'b0, 32'd0, 32'd0, 1'b1));
      shadow_rel[s] = rel;
      shadow_blk[s] = blk;
      shadow_dirty[s] = 0;
   endtask

   task automatic pool_sync();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS && n < SYNC_MAX; i++) begin
         if (shadow_dirty[i]) begin
            expected_rsp.push_back(mk(1'b0, i[5:0], 1'b0, 32'd0, 1'b1, shadow_rel[i],
                                      shadow_blk[i], 1'b0));
            shadow_dirty[i] = 0;
            n++;
         end
      end
      if (n > 0) expected_rsp[expected_rsp.size() - 1].last = 1'b1;
      for (int i = 0; i < SLOTS; i++) shadow_pin[i] = 0;
      victim_ptr = 0;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            shadow_rel[i] = 0; shadow_blk[i] = 0; shadow_pin[i] = 0; shadow_dirty[i] = 0;
         end
         victim_ptr = 0;
         expected_rsp.delete();
         fail_count = 0;
         rsp_count = 0; hit_count = 0; wb_count = 0; full_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected response, slot %0d", rsp_slot_index);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("found", 32'(e.found), 32'(rsp_found));
               check_field("slot_index", 32'(e.slot_index), 32'(rsp_slot_index));
               check_field("no_free_error", 32'(e.no_free_error), 32'(rsp_no_free_error));
               check_field("assigned_block", e.assigned_block, rsp_assigned_block);
               check_field("writeback_valid", 32'(e.writeback_valid),
                           32'(rsp_writeback_valid));
               check_field("writeback_rel", e.writeback_rel, rsp_writeback_rel);
               check_field("writeback_block", e.writeback_block, rsp_writeback_block);
               check_field("last", 32'(e.last), 32'(rsp_last));
               if (e.found) hit_count++;
               if (e.writeback_valid) wb_count++;
               if (e.no_free_error) full_count++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_mode)
               MODE_ALLOC: begin
                  pool_alloc(req_rel_id, req_new_block ? req_relation_size : req_block_num);
               end
               MODE_MARK: begin
                  if (req_slot_select < SLOTS) begin
                     shadow_dirty[req_slot_select] = 1;
                     if (req_release_pin && shadow_pin[req_slot_select] != 0)
                        shadow_pin[req_slot_select]--;
                  end
               end
               MODE_SYNC: begin
                  pool_sync();
               end
               default: begin
                  for (int i = 0; i < SLOTS; i++) begin
                     shadow_rel[i] = 0; shadow_dirty[i] = 0; shadow_pin[i] = 0;
                  end
                  victim_ptr = 0;
               end
            endcase
         end
      end
   end

endmodule

// ----- test/tb_local_buffer_pool_manager.sv -----
// ----------------------------------------------------------------------------
// tb_local_buffer_pool_manager
// Directed and random requests against the buffer pool manager: hits, misses,
// victim write-backs, full pool, repeated pins, sync and pool reset, with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_local_buffer_pool_manager;
   import lbpm_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [31:0] req_rel_id;
   logic [31:0] req_block_num;
   logic        req_new_block;
   logic [31:0] req_relation_size;
   logic [5:0]  req_slot_select;
   logic        req_release_pin;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [5:0]  rsp_slot_index;
   logic        rsp_no_free_error;
   logic [31:0] rsp_assigned_block;
   logic        rsp_writeback_valid;
   logic [31:0] rsp_writeback_rel;
   logic [31:0] rsp_writeback_block;
   logic        rsp_last;
   int          fail_count, pending_count, rsp_count, hit_count, wb_count, full_count;
   int          burst_left;
   int          req_total;

   local_buffer_pool_manager DUT (.*);

   lbpm_scoreboard CHK (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern: quiet stretches, then random stalls
   initial begin
      int phase;
      rsp_stall = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase = (phase + 1) % 600;
         if (phase < 150) rsp_stall <= 0;
         else if (phase < 400) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // one request; bursts with random gaps between them
   task automatic send(logic [1:0] m, logic [31:0] rel, logic [31:0] blk, logic nb,
                       logic [31:0] rsz, logic [5:0] sel, logic rp);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1;
      req_mode <= m; req_rel_id <= rel; req_block_num <= blk; req_new_block <= nb;
      req_relation_size <= rsz; req_slot_select <= sel; req_release_pin <= rp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      // valid drops only at the end of a burst
      if (burst_left == 0) req_valid <= 0;
      req_total++;
   endtask

   task automatic alloc(logic [31:0] rel, logic [31:0] blk);
      send(MODE_ALLOC, rel, blk, 1'b0, $urandom, 6'($urandom), 1'($urandom));
   endtask

   task automatic mark(logic [5:0] sel, logic rp);
      send(MODE_MARK, $urandom, $urandom, 1'($urandom), $urandom, sel, rp);
   endtask

   task automatic drain();
      if (burst_left != 0) begin
         req_valid <= 0;
         burst_left = 0;
      end
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [31:0] rel, blk;
      int r;
      req_valid = 0; req_mode = MODE_ALLOC; req_rel_id = 0; req_block_num = 0;
      req_new_block = 0; req_relation_size = 0; req_slot_select = 0;
      req_release_pin = 0; burst_left = 0; req_total = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      alloc(32'd0, 32'd0);                        // invalid relation never hits
      alloc(32'd0, 32'd0);
      alloc(32'hFFFFFFFF, 32'hFFFFFFFE);
      alloc(32'hFFFFFFFF, 32'hFFFFFFFE);          // hit
      send(MODE_ALLOC, 32'd7, 32'd5, 1, 32'hFFFFFFFE, 6'd63, 1);
      send(MODE_ALLOC, 32'd7, 32'd0, 1, 32'hFFFFFFFE, 6'd0, 0);  // new block hit
      mark(6'd2, 1);
      mark(6'd2, 1);                               // unpin to zero
      mark(6'd63, 0);
      alloc(32'd9, 32'd1);
      send(MODE_SYNC, 0, 0, 0, 0, 0, 0);
      send(MODE_SYNC, 0, 0, 0, 0, 0, 0);           // nothing dirty
      for (int i = 0; i < 64; i++) alloc(32'd100 + i, i);   // fill the pool
      alloc(32'd500, 32'd1);                       // all pinned
      for (int i = 0; i < 6; i++) mark(i[5:0], 1);
      alloc(32'd501, 32'd2);                       // dirty victim
      send(MODE_RESET, $urandom, $urandom, 1, $urandom, 6'h3F, 1);
      drain();

      // repeated pins on one slot
      for (int i = 0; i < 4; i++) alloc(32'd42, 32'd42);
      mark(6'd0, 1);
      alloc(32'd43, 32'd43);
      for (int i = 0; i < 64; i++) alloc(32'd44, i);
      send(MODE_SYNC, 0, 0, 0, 0, 0, 0);
      drain();

      // random: small tag space so hits and write-backs are common
      for (int n = 0; n < 200; n++) begin
         r = $urandom_range(0, 99);
         rel = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6);
         blk = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 9);
         if (r < 55)
            send(MODE_ALLOC, rel, blk, $urandom_range(0, 4) == 0,
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 9),
                 6'($urandom), 1'($urandom));
         else if (r < 88) mark(6'($urandom), 1'($urandom));
         else if (r < 97) send(MODE_SYNC, $urandom, $urandom, 1'($urandom), $urandom,
                               6'($urandom), 1'($urandom));
         else send(MODE_RESET, $urandom, $urandom, 1'($urandom), $urandom, 6'($urandom),
                   1'($urandom));
         if (n == 100) drain();
      end
      drain();

      $display("Ran %0d requests: %0d responses, %0d hits, %0d write-backs, %0d pool-full.",
               req_total, rsp_count, hit_count, wb_count, full_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lbpm_pkg.sv
rtl/lbpm_slot_ram.sv
rtl/local_buffer_pool_manager.sv
rtl/lbpm_checker.sv
test/lbpm_checker.sv
test/tb_local_buffer_pool_manager.sv
